// ===== rtl/ppf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants for the path point frame block
// Widths, unit constant and the state codes of both sequencers.
// ----------------------------------------------------------------------------
package ppf_pkg;

  localparam int PointW = 32;
  localparam int UnitW  = 16;
  localparam int MagW   = 48;            // cross product magnitudes below 2^47
  localparam int RedW   = 20;            // magnitudes after scaling, below 2^20
  localparam int SumW   = 42;            // sum of three squares below 2^42
  localparam int RootW  = 21;
  localparam int QW     = 15;            // quotient, at most 16384

  localparam logic [QW-1:0] UnitOne = 15'd16384;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SCALE,
    U_SQ,
    U_ROOT,
    U_DIV,
    U_DONE
  } unit_state_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_NRM,
    F_NWAIT,
    F_LEFT,
    F_LWAIT,
    F_OUT
  } frame_state_t;

endpackage : ppf_pkg
`default_nettype wire

// ===== rtl/ppf_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_unit: vector normalizer
// Scales a 3-vector to 20 bits, squares, takes a bit-pair serial square root
// and forms each Q2.14 component by restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module ppf_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire  signed [ppf_pkg::MagW:0] vx,
  input  wire  signed [ppf_pkg::MagW:0] vy,
  input  wire  signed [ppf_pkg::MagW:0] vz,
  output logic                   done,
  output logic signed [ppf_pkg::UnitW-1:0] ux,
  output logic signed [ppf_pkg::UnitW-1:0] uy,
  output logic signed [ppf_pkg::UnitW-1:0] uz
);
  import ppf_pkg::*;

  unit_state_t state, state_next;
  logic [MagW-1:0] mag [3];
  logic            neg [3];
  logic [1:0]      idx;
  logic [5:0]      cnt;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] rem;
  logic [RootW-1:0] root;
  logic [16:0]       dnum;
  logic [RootW+1:0]  drem;
  logic [QW+1:0]     quo;
  logic signed [UnitW-1:0] res [3];

  logic [MagW-1:0] maxm;
  logic [RedW-1:0] cur;
  logic [2*RedW-1:0] sq;
  logic [RootW+1:0] dtrial;
  logic [QW+1:0]    qfin;

  always_comb begin
    maxm = (mag[0] | mag[1]) | mag[2];
    cur  = mag[idx][RedW-1:0];
    sq   = cur * cur;
    dtrial = {drem[RootW:0], dnum[16]} - {1'b0, root, 1'b0};
    qfin = (quo + 17'd1) >> 1;
    state_next = state;
    unique case (state)
      U_IDLE:  if (start) state_next = U_SCALE;
      U_SCALE: if (maxm[MagW-1:RedW] == '0) state_next = U_SQ;
      U_SQ:    if (idx == 2'd2) state_next = U_ROOT;
      U_ROOT:  if (cnt == 6'd20) state_next = (sum == '0 && root == '0 && rem == '0)
                                  ? U_DONE : U_DIV;
      U_DIV:   if (cnt == 6'd17 && idx == 2'd2) state_next = U_DONE;
      U_DONE:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  logic [SumW-1:0] tr;
  logic [SumW-1:0] rt;
  always_comb begin
    tr = {rem[SumW-3:0], sum[SumW-1 -: 2]};
    rt = {{(SumW-RootW-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
    done <= (state == U_DONE);
    unique case (state)
      U_IDLE: begin
        if (start) begin
          neg[0] <= vx < 0; neg[1] <= vy < 0; neg[2] <= vz < 0;
          mag[0] <= vx < 0 ? MagW'(-vx) : MagW'(vx);
          mag[1] <= vy < 0 ? MagW'(-vy) : MagW'(vy);
          mag[2] <= vz < 0 ? MagW'(-vz) : MagW'(vz);
        end
        idx <= '0; sum <= '0;
      end
      U_SCALE: begin
        // shift right one bit a cycle until all fit in 20 bits
        if (maxm[MagW-1:RedW] != '0) begin
          mag[0] <= mag[0] >> 1; mag[1] <= mag[1] >> 1; mag[2] <= mag[2] >> 1;
        end
      end
      U_SQ: begin
        sum <= sum + SumW'(sq);
        idx <= idx + 2'd1;
        cnt <= '0; rem <= '0; root <= '0;
      end
      U_ROOT: begin
        // two radicand bits per cycle
        if (tr >= rt) begin
          rem  <= tr - rt;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= tr;
          root <= {root[RootW-2:0], 1'b0};
        end
        sum <= {sum[SumW-3:0], 2'b00};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd20) begin
          idx <= '0;
          res[0] <= '0; res[1] <= '0; res[2] <= '0;
        end
        if (cnt == 6'd20) begin
          // mag*65536 / 2L: preload the high part, feed the last 17 bits
          cnt <= '0;
          quo <= '0;
          drem <= {4'd0, mag[0][RedW-1:1]};
          dnum <= {mag[0][0], 16'd0};
        end
      end
      U_DIV: begin
        // quotient of mag*32768 / L, one bit a cycle, then round halves up
        if (cnt < 6'd17) begin
          if (!dtrial[RootW+1]) begin
            drem <= dtrial;
            quo  <= {quo[QW:0], 1'b1};
          end else begin
            drem <= {drem[RootW:0], dnum[16]};
            quo  <= {quo[QW:0], 1'b0};
          end
          dnum <= dnum << 1;
          cnt  <= cnt + 6'd1;
        end else begin
          res[idx] <= neg[idx] ? -$signed({1'b0, (qfin > UnitOne ? UnitOne : QW'(qfin))})
                               :  $signed({1'b0, (qfin > UnitOne ? UnitOne : QW'(qfin))});
          idx  <= idx + 2'd1;
          cnt  <= '0; quo <= '0;
          drem <= {4'd0, mag[idx == 2'd2 ? 2'd0 : idx + 2'd1][RedW-1:1]};
          dnum <= {mag[idx == 2'd2 ? 2'd0 : idx + 2'd1][0], 16'd0};
        end
      end
      U_DONE: begin
        ux <= res[0]; uy <= res[1]; uz <= res[2];
      end
      default: ;
    endcase
  end

endmodule : ppf_unit
`default_nettype wire

// ===== rtl/path_point_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// path_point_frame: local frame of a 3D path
// Emits middle point, unit normal and unit left vector, one point late.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | point_x, point_y, point_z (tdata, 96 bits)
//  m_axis  | out | mid, normal, left (tdata, 192 bits)
// Each item makes two passes of the shared normalizer, each scaling the
// vector, then taking 21 root steps and three divisions (a zero vector
// skips the divisions), with the cross product between the two passes.
// Synchronous reset restores the start normal (0,1,0).
// The result waits in its register; input is held off until it is taken.
// ----------------------------------------------------------------------------
module path_point_frame (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [95:0]  s_axis_tdata,   // point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [191:0] m_axis_tdata    // mid_x,y,z, normal_x,y,z, left_x,y,z
);
  import ppf_pkg::*;

  frame_state_t st, st_next;

  logic signed [PointW-1:0] older [3], newer [3], pin [3];
  logic signed [UnitW-1:0]  lastn [3], nu [3];
  logic signed [PointW+1:0] d1 [3], n [3];
  logic signed [MagW:0] vx, vy, vz;
  logic signed [MagW:0] cr [3];
  logic signed [UnitW-1:0] ux, uy, uz;
  logic ustart, udone;
  logic [5:0] mcnt;
  logic signed [MagW:0] acc;
  logic short_n;
  logic [2:0] am [3];
  logic [7:0] sumsq;
  logic signed [31:0] dp [3];
  logic signed [33:0] dot;

  ppf_unit u_unit (.clk, .rst, .start(ustart), .vx, .vy, .vz, .done(udone),
                   .ux, .uy, .uz);

  always_comb begin
    short_n = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (n[i] >= 8 || n[i] <= -8) short_n = 1'b0;
      am[i] = n[i][PointW+1] ? 3'(-n[i]) : 3'(n[i]);
    end
    sumsq = 8'(am[0]) * 8'(am[0]) + 8'(am[1]) * 8'(am[1]) + 8'(am[2]) * 8'(am[2]);
    if (short_n)
      short_n = (sumsq <= 8'd42);
    if (st == F_NRM && short_n) begin
      vx = (MagW+1)'(lastn[0]); vy = (MagW+1)'(lastn[1]); vz = (MagW+1)'(lastn[2]);
    end else if (st == F_NRM) begin
      vx = (MagW+1)'(n[0]); vy = (MagW+1)'(n[1]); vz = (MagW+1)'(n[2]);
    end else begin
      vx = cr[0]; vy = cr[1]; vz = cr[2];
    end
    ustart = (st == F_NRM) || (st == F_LEFT && mcnt == 6'd6);
    s_axis_tready = (st == F_IDLE);
    dp[0] = 32'(lastn[0]) * 32'(ux);
    dp[1] = 32'(lastn[1]) * 32'(uy);
    dp[2] = 32'(lastn[2]) * 32'(uz);
    dot = 34'(dp[0]) + 34'(dp[1]) + 34'(dp[2]);
    st_next = st;
    unique case (st)
      F_IDLE:  if (s_axis_tvalid) st_next = F_NRM;
      F_NRM:   st_next = F_NWAIT;
      F_NWAIT: if (udone) st_next = F_LEFT;
      F_LEFT:  if (mcnt == 6'd6) st_next = F_LWAIT;
      F_LWAIT: if (udone) st_next = F_OUT;
      F_OUT:   if (m_axis_tready) st_next = F_IDLE;
      default: st_next = F_IDLE;
    endcase
  end

  // cross product terms, one 34x16 product a cycle
  logic signed [PointW+1:0] ma;
  logic signed [UnitW-1:0]  mb;
  logic signed [MagW:0]     prod;
  always_comb begin
    unique case (mcnt[2:0])
      3'd0: begin ma = d1[1]; mb = nu[2]; end
      3'd1: begin ma = d1[2]; mb = nu[1]; end
      3'd2: begin ma = d1[2]; mb = nu[0]; end
      3'd3: begin ma = d1[0]; mb = nu[2]; end
      3'd4: begin ma = d1[0]; mb = nu[1]; end
      default: begin ma = d1[1]; mb = nu[0]; end
    endcase
    prod = (MagW+1)'(ma) * (MagW+1)'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        older[i] <= '0; newer[i] <= '0;
      end
      lastn[0] <= '0; lastn[1] <= 16'sd16384; lastn[2] <= '0;
    end else begin
      st <= st_next;
      unique case (st)
        F_IDLE: if (s_axis_tvalid) begin
          pin[0] <= s_axis_tdata[31:0];
          pin[1] <= s_axis_tdata[63:32];
          pin[2] <= s_axis_tdata[95:64];
          for (int i = 0; i < 3; i++) begin
            d1[i] <= (PointW+2)'(newer[i]) - (PointW+2)'(older[i]);
            n[i]  <= (PointW+2)'(newer[i]) - (PointW+2)'(older[i]) + (PointW+2)'(newer[i])
                   - (PointW+2)'($signed(s_axis_tdata[32*i +: 32]));
          end
        end
        F_NWAIT: if (udone) begin
          // flip when pointing against the last normal
          nu[0] <= dot < 0 ? -ux : ux;
          nu[1] <= dot < 0 ? -uy : uy;
          nu[2] <= dot < 0 ? -uz : uz;
          mcnt <= '0;
        end
        F_LEFT: begin
          if (mcnt[0] == 1'b0) acc <= prod;
          else cr[mcnt[2:1]] <= acc - prod;
          mcnt <= mcnt + 6'd1;
        end
        F_LWAIT: if (udone) begin
          m_axis_tdata <= {uz, uy, ux, nu[2], nu[1], nu[0], newer[2], newer[1], newer[0]};
          m_axis_tvalid <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            older[i] <= newer[i]; newer[i] <= pin[i]; lastn[i] <= nu[i];
          end
        end
        F_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule : path_point_frame
`default_nettype wire
